@@ sv/dqf_pkg.sv @@
// Package for the diffusion quadrature factor block.
// Holds the default number format shared by the channel interfaces and the top level.
package dqf_pkg;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
endpackage

@@ sv/dqf_ifs.sv @@
// Valid/ready channel interfaces for the quadrature point word and the factor word.
// Depends on dqf_pkg for the default data width.
interface dqf_in_if #(
  parameter int DW = dqf_pkg::DATA_WIDTH_DEF
);
  logic          valid;
  logic          ready;
  logic          mode;
  logic [DW-2:0] weight;
  logic [DW-1:0] jac_11;
  logic [DW-1:0] jac_12;
  logic [DW-1:0] jac_13;
  logic [DW-1:0] jac_21;
  logic [DW-1:0] jac_22;
  logic [DW-1:0] jac_23;
  logic [DW-1:0] jac_31;
  logic [DW-1:0] jac_32;
  logic [DW-1:0] jac_33;
  modport source (output valid, mode, weight, jac_11, jac_12, jac_13, jac_21, jac_22, jac_23,
                  jac_31, jac_32, jac_33, input ready);
  modport sink (input valid, mode, weight, jac_11, jac_12, jac_13, jac_21, jac_22, jac_23,
                jac_31, jac_32, jac_33, output ready);
endinterface

interface dqf_out_if #(
  parameter int DW = dqf_pkg::DATA_WIDTH_DEF
);
  logic          valid;
  logic          ready;
  logic [DW-1:0] factor_xx;
  logic [DW-1:0] factor_xy;
  logic [DW-1:0] factor_xz;
  logic [DW-1:0] factor_yy;
  logic [DW-1:0] factor_yz;
  logic [DW-1:0] factor_zz;
  logic          singular;
  modport source (output valid, factor_xx, factor_xy, factor_xz, factor_yy, factor_yz,
                  factor_zz, singular, input ready);
  modport sink (input valid, factor_xx, factor_xy, factor_xz, factor_yy, factor_yz,
                factor_zz, singular, output ready);
endinterface

@@ sv/diffusion_quadrature_factors_top.sv @@
// Top level of the diffusion quadrature factor pipeline.
// Depends on dqf_pkg and the channel interfaces in dqf_ifs.sv.
//
// Usage:
//   in_item  : one quadrature point word per handshake (mode, weight, Jacobian).
//   out_item : one factor word per point, in order, with the singular flag.
//   cfg_we / cfg_wdata : write the diffusion coefficient; reset value is 1.0.
// Throughput is one word per cycle when the output is not stalled. The stages, at
// the default Q16.16, are: four product/sum stages, one restoring divider stage
// per quotient bit, a rounding stage, the final multiply stage and the output
// register. All stages advance together; when the receiver holds out_item.ready
// low with a word waiting, the whole pipeline holds and in_item.ready drops, so
// nothing is lost or repeated. Reset clears every valid bit and loads the
// coefficient with 1.0; the pipeline accepts words in the first cycle after reset.
module diffusion_quadrature_factors_top #(
  parameter int DATA_WIDTH = dqf_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = dqf_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [DATA_WIDTH-1:0] cfg_wdata,
  dqf_in_if.sink                in_item,
  dqf_out_if.source             out_item
);
  localparam int DW = DATA_WIDTH;
  localparam int FB = FRAC_BITS;
  localparam int PW = 2 * DW;
  localparam int NW = DW + FB;
  localparam logic [PW-1:0] MAXM = (PW'(1) << (DW - 1)) - PW'(1);
  localparam logic [PW-1:0] RND  = PW'(1) << (FB - 1);
  localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

  typedef struct packed {
    logic [DW:0]        rem;
    logic [NW-1:0]      q;
    logic [NW-1:0]      dd;
    logic [DW-1:0]      ud;
    logic               neg;
    logic               sing;
    logic               mode;
    logic [5:0][DW-1:0] g;
  } dv_t;

  function automatic logic [DW-1:0] sat_of(input logic [PW-1:0] m, input logic neg);
    logic [PW-1:0] nm;
    logic [DW-1:0] res;
    nm = ~m + PW'(1);
    if (neg) begin
      res = (m > MAXM + PW'(1)) ? MINV : nm[DW-1:0];
    end else begin
      res = (m > MAXM) ? MAXV : m[DW-1:0];
    end
    return res;
  endfunction

  function automatic logic [DW-1:0] smul(input logic [DW-1:0] a, input logic [DW-1:0] b);
    logic [DW-1:0] ma;
    logic [DW-1:0] mb;
    logic [PW-1:0] p;
    ma = a[DW-1] ? ~a + DW'(1) : a;
    mb = b[DW-1] ? ~b + DW'(1) : b;
    p  = PW'(ma) * PW'(mb);
    p  = p + RND;
    return sat_of(p >> FB, a[DW-1] ^ b[DW-1]);
  endfunction

  function automatic logic [DW-1:0] sadd(input logic [DW-1:0] a, input logic [DW-1:0] b);
    logic [DW:0] s;
    s = {a[DW-1], a} + {b[DW-1], b};
    if (s[DW] != s[DW-1]) begin
      return s[DW] ? MINV : MAXV;
    end
    return s[DW-1:0];
  endfunction

  function automatic logic [DW-1:0] ssub(input logic [DW-1:0] a, input logic [DW-1:0] b);
    logic [DW:0] s;
    s = {a[DW-1], a} - {b[DW-1], b};
    if (s[DW] != s[DW-1]) begin
      return s[DW] ? MINV : MAXV;
    end
    return s[DW-1:0];
  endfunction

  logic [DW-1:0] coef_r;
  logic          adv;
  logic          v1_r, v2_r, v3_r, v4_r, vr_r, vm_r, vo_r;
  logic [NW-1:0] dvv_r;

  logic          s1_mode_r;
  logic [DW-1:0] s1_num_r;
  logic [DW-1:0] s1_pr_r [24];
  logic [DW-1:0] s1_j31_r, s1_j32_r, s1_j33_r;
  logic [DW-1:0] pr_nxt [24];

  logic          s2_mode_r;
  logic [DW-1:0] s2_num_r;
  logic [DW-1:0] s2_tr_r [6];
  logic [DW-1:0] s2_a_r [9];
  logic [DW-1:0] s2_det2_r;
  logic [DW-1:0] s2_s_r [3];

  logic          s3_mode_r;
  logic [DW-1:0] s3_num_r;
  logic [DW-1:0] s3_d_r;
  logic [DW-1:0] s3_tr4_r, s3_tr5_r;
  logic [DW-1:0] s3_m_r [18];
  logic [DW-1:0] s3_det2_r;
  logic [DW-1:0] s3_s_r [3];
  logic [DW-1:0] m_nxt [18];

  logic               s4_mode_r;
  logic [DW-1:0]      s4_num_r;
  logic [DW-1:0]      s4_det_r;
  logic [5:0][DW-1:0] s4_g_r;

  dv_t dv_in  [NW];
  dv_t dv_nxt [NW];
  dv_t dv_r   [NW];

  logic               r_mode_r, r_sing_r;
  logic [DW-1:0]      r_c_r;
  logic [5:0][DW-1:0] r_g_r;
  logic [DW:0]        rnd_diff;
  logic               rnd_up;
  logic [NW:0]        q_rnd;

  logic               m_mode_r, m_sing_r;
  logic [5:0][DW-1:0] m_f_r;

  logic [5:0][DW-1:0] o_f_r;
  logic               o_sing_r;

  // Hold every stage while a finished word waits at a stalled output.
  assign adv          = !vo_r || out_item.ready;
  assign in_item.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= DW'(1) << FB;
    end else if (cfg_we) begin
      coef_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
      dvv_r <= '0;
      vr_r  <= 1'b0;
      vm_r  <= 1'b0;
      vo_r  <= 1'b0;
    end else if (adv) begin
      v1_r  <= in_item.valid;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      v4_r  <= v3_r;
      dvv_r <= {dvv_r[NW-2:0], v4_r};
      vr_r  <= dvv_r[NW-1];
      vm_r  <= vr_r;
      vo_r  <= vm_r;
    end
  end

  // Stage 1: pairwise Jacobian products and the scaled weight.
  always_comb begin
    pr_nxt[0]  = smul(in_item.jac_11, in_item.jac_22);
    pr_nxt[1]  = smul(in_item.jac_12, in_item.jac_21);
    pr_nxt[2]  = smul(in_item.jac_12, in_item.jac_23);
    pr_nxt[3]  = smul(in_item.jac_13, in_item.jac_21);
    pr_nxt[4]  = smul(in_item.jac_13, in_item.jac_22);
    pr_nxt[5]  = smul(in_item.jac_11, in_item.jac_23);
    pr_nxt[6]  = smul(in_item.jac_22, in_item.jac_33);
    pr_nxt[7]  = smul(in_item.jac_23, in_item.jac_32);
    pr_nxt[8]  = smul(in_item.jac_23, in_item.jac_31);
    pr_nxt[9]  = smul(in_item.jac_21, in_item.jac_33);
    pr_nxt[10] = smul(in_item.jac_21, in_item.jac_32);
    pr_nxt[11] = smul(in_item.jac_22, in_item.jac_31);
    pr_nxt[12] = smul(in_item.jac_13, in_item.jac_32);
    pr_nxt[13] = smul(in_item.jac_12, in_item.jac_33);
    pr_nxt[14] = smul(in_item.jac_11, in_item.jac_33);
    pr_nxt[15] = smul(in_item.jac_13, in_item.jac_31);
    pr_nxt[16] = smul(in_item.jac_12, in_item.jac_31);
    pr_nxt[17] = smul(in_item.jac_11, in_item.jac_32);
    pr_nxt[18] = smul(in_item.jac_21, in_item.jac_21);
    pr_nxt[19] = smul(in_item.jac_22, in_item.jac_22);
    pr_nxt[20] = smul(in_item.jac_21, in_item.jac_11);
    pr_nxt[21] = smul(in_item.jac_22, in_item.jac_12);
    pr_nxt[22] = smul(in_item.jac_11, in_item.jac_11);
    pr_nxt[23] = smul(in_item.jac_12, in_item.jac_12);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_mode_r <= in_item.mode;
      s1_num_r  <= smul({1'b0, in_item.weight}, coef_r);
      s1_pr_r   <= pr_nxt;
      s1_j31_r  <= in_item.jac_31;
      s1_j32_r  <= in_item.jac_32;
      s1_j33_r  <= in_item.jac_33;
    end
  end

  // Stage 2: determinant triple products, adjugate entries, 2D sums.
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_mode_r  <= s1_mode_r;
      s2_num_r   <= s1_num_r;
      s2_tr_r[0] <= smul(s1_pr_r[0], s1_j33_r);
      s2_tr_r[1] <= smul(s1_pr_r[2], s1_j31_r);
      s2_tr_r[2] <= smul(s1_pr_r[3], s1_j32_r);
      s2_tr_r[3] <= smul(s1_pr_r[4], s1_j31_r);
      s2_tr_r[4] <= smul(s1_pr_r[1], s1_j33_r);
      s2_tr_r[5] <= smul(s1_pr_r[5], s1_j32_r);
      s2_a_r[0]  <= ssub(s1_pr_r[6], s1_pr_r[7]);
      s2_a_r[1]  <= ssub(s1_pr_r[8], s1_pr_r[9]);
      s2_a_r[2]  <= ssub(s1_pr_r[10], s1_pr_r[11]);
      s2_a_r[3]  <= ssub(s1_pr_r[12], s1_pr_r[13]);
      s2_a_r[4]  <= ssub(s1_pr_r[14], s1_pr_r[15]);
      s2_a_r[5]  <= ssub(s1_pr_r[16], s1_pr_r[17]);
      s2_a_r[6]  <= ssub(s1_pr_r[2], s1_pr_r[4]);
      s2_a_r[7]  <= ssub(s1_pr_r[3], s1_pr_r[5]);
      s2_a_r[8]  <= ssub(s1_pr_r[0], s1_pr_r[1]);
      s2_det2_r  <= ssub(s1_pr_r[0], s1_pr_r[1]);
      s2_s_r[0]  <= sadd(s1_pr_r[18], s1_pr_r[19]);
      s2_s_r[1]  <= sadd(s1_pr_r[20], s1_pr_r[21]);
      s2_s_r[2]  <= sadd(s1_pr_r[22], s1_pr_r[23]);
    end
  end

  // Stage 3: first four terms of the determinant sum, adjugate column products.
  always_comb begin
    m_nxt[0]  = smul(s2_a_r[0], s2_a_r[0]);
    m_nxt[1]  = smul(s2_a_r[3], s2_a_r[3]);
    m_nxt[2]  = smul(s2_a_r[6], s2_a_r[6]);
    m_nxt[3]  = smul(s2_a_r[0], s2_a_r[1]);
    m_nxt[4]  = smul(s2_a_r[3], s2_a_r[4]);
    m_nxt[5]  = smul(s2_a_r[6], s2_a_r[7]);
    m_nxt[6]  = smul(s2_a_r[0], s2_a_r[2]);
    m_nxt[7]  = smul(s2_a_r[3], s2_a_r[5]);
    m_nxt[8]  = smul(s2_a_r[6], s2_a_r[8]);
    m_nxt[9]  = smul(s2_a_r[1], s2_a_r[1]);
    m_nxt[10] = smul(s2_a_r[4], s2_a_r[4]);
    m_nxt[11] = smul(s2_a_r[7], s2_a_r[7]);
    m_nxt[12] = smul(s2_a_r[1], s2_a_r[2]);
    m_nxt[13] = smul(s2_a_r[4], s2_a_r[5]);
    m_nxt[14] = smul(s2_a_r[7], s2_a_r[8]);
    m_nxt[15] = smul(s2_a_r[2], s2_a_r[2]);
    m_nxt[16] = smul(s2_a_r[5], s2_a_r[5]);
    m_nxt[17] = smul(s2_a_r[8], s2_a_r[8]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_mode_r <= s2_mode_r;
      s3_num_r  <= s2_num_r;
      s3_d_r    <= ssub(sadd(sadd(s2_tr_r[0], s2_tr_r[1]), s2_tr_r[2]), s2_tr_r[3]);
      s3_tr4_r  <= s2_tr_r[4];
      s3_tr5_r  <= s2_tr_r[5];
      s3_m_r    <= m_nxt;
      s3_det2_r <= s2_det2_r;
      s3_s_r    <= s2_s_r;
    end
  end

  // Stage 4: finish the determinant and the dot products, select by mode.
  always_ff @(posedge clk) begin
    if (adv) begin
      s4_mode_r <= s3_mode_r;
      s4_num_r  <= s3_num_r;
      if (s3_mode_r) begin
        s4_det_r <= ssub(ssub(s3_d_r, s3_tr4_r), s3_tr5_r);
        for (int k = 0; k < 6; k++) begin
          s4_g_r[k] <= sadd(sadd(s3_m_r[3*k], s3_m_r[3*k+1]), s3_m_r[3*k+2]);
        end
      end else begin
        s4_det_r  <= s3_det2_r;
        s4_g_r[0] <= s3_s_r[0];
        s4_g_r[1] <= s3_s_r[1];
        s4_g_r[2] <= s3_s_r[2];
        s4_g_r[3] <= '0;
        s4_g_r[4] <= '0;
        s4_g_r[5] <= '0;
      end
    end
  end

  // Restoring divider: one quotient bit per stage.
  always_comb begin
    dv_in[0].rem  = '0;
    dv_in[0].q    = '0;
    dv_in[0].dd   = {(s4_num_r[DW-1] ? ~s4_num_r + DW'(1) : s4_num_r), {FB{1'b0}}};
    dv_in[0].ud   = s4_det_r[DW-1] ? ~s4_det_r + DW'(1) : s4_det_r;
    dv_in[0].neg  = s4_num_r[DW-1] ^ s4_det_r[DW-1];
    dv_in[0].sing = (s4_det_r == '0);
    dv_in[0].mode = s4_mode_r;
    dv_in[0].g    = s4_g_r;
  end

  for (genvar k = 0; k < NW; k++) begin : g_div
    logic [DW:0] rs;
    logic        ge;
    if (k > 0) begin : g_link
      assign dv_in[k] = dv_r[k-1];
    end
    always_comb begin
      rs         = {dv_in[k].rem[DW-1:0], dv_in[k].dd[NW-1]};
      ge         = (rs >= {1'b0, dv_in[k].ud});
      dv_nxt[k]  = dv_in[k];
      dv_nxt[k].rem = ge ? rs - {1'b0, dv_in[k].ud} : rs;
      dv_nxt[k].q   = {dv_in[k].q[NW-2:0], ge};
      dv_nxt[k].dd  = dv_in[k].dd << 1;
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_r[k] <= dv_nxt[k];
      end
    end
  end

  // Round the quotient half away from zero, then apply sign and saturate.
  always_comb begin
    rnd_diff = {1'b0, dv_r[NW-1].ud} - dv_r[NW-1].rem;
    rnd_up   = (dv_r[NW-1].rem >= rnd_diff);
    q_rnd    = {1'b0, dv_r[NW-1].q} + (NW+1)'(rnd_up);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r_mode_r <= dv_r[NW-1].mode;
      r_sing_r <= dv_r[NW-1].sing;
      r_c_r    <= sat_of(PW'(q_rnd), dv_r[NW-1].neg);
      r_g_r    <= dv_r[NW-1].g;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_mode_r <= r_mode_r;
      m_sing_r <= r_sing_r;
      for (int k = 0; k < 6; k++) begin
        m_f_r[k] <= smul(r_c_r, r_g_r[k]);
      end
    end
  end

  // Output register: negate the 2D off-diagonal, drop everything when singular.
  always_ff @(posedge clk) begin
    if (adv) begin
      o_sing_r <= m_sing_r;
      for (int k = 0; k < 6; k++) begin
        if (m_sing_r) begin
          o_f_r[k] <= '0;
        end else if (k == 1 && !m_mode_r) begin
          o_f_r[k] <= ssub('0, m_f_r[k]);
        end else begin
          o_f_r[k] <= m_f_r[k];
        end
      end
    end
  end

  assign out_item.valid     = vo_r;
  assign out_item.factor_xx = o_f_r[0];
  assign out_item.factor_xy = o_f_r[1];
  assign out_item.factor_xz = o_f_r[2];
  assign out_item.factor_yy = o_f_r[3];
  assign out_item.factor_yz = o_f_r[4];
  assign out_item.factor_zz = o_f_r[5];
  assign out_item.singular  = o_sing_r;
endmodule
